// ===== rtl/core/sop_pkg.sv =====
// Shared types and constants of the sine oscillator with phase modulation and gain ramp.
package sop_pkg;

    // Field widths
    localparam int PHASE_W     = 32;   // phase accumulator and offset
    localparam int INC_W       = 31;   // phase increment register
    localparam int GAIN_W      = 32;   // gain in Q1.31
    localparam int TGT_W       = 16;   // gain target in Q1.15
    localparam int LEN_W       = 16;   // ramp length
    localparam int SAMPLE_W    = 16;   // output sample
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 31;

    localparam int DEF_TABLE_ADDRESS_BITS = 10;

    // Pipeline depth: index, five sine stages, gain multiply, round/saturate
    localparam int PIPE_STAGES = 8;
    localparam int SINE_STAGES = 5;

    // Register reset values
    localparam logic [INC_W-1:0] RST_PHASE_INC   = 31'd42949673;
    localparam logic [TGT_W-1:0] RST_GAIN_TARGET = 16'd0;
    localparam logic [LEN_W-1:0] RST_RAMP_LEN    = 16'd480;

    localparam logic [TGT_W-1:0] GAIN_UNITY = 16'd32768;

    // sin(pi/2*x) ~ x*(A - x^2*(B - x^2*C)), Q2.30
    localparam logic [30:0] COEF_A  = 31'd1686629713;
    localparam logic [29:0] COEF_B  = 30'd688904866;
    localparam logic [26:0] COEF_C  = 27'd76016977;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_INC   = 2'd0,
        CFG_GAIN_TARGET = 2'd1,
        CFG_RAMP_LEN    = 2'd2
    } t_cfg_idx;

    // Handshake between the top level and the step divider
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== rtl/core/sine_oscillator_pm_gain_ramp.sv =====
// Top level: phase-modulated sine oscillator with linear gain ramp.
//
// Every item accepted on the slave stream is one sample tick carrying a signed
// phase offset; it yields exactly one signed Q1.15 sample on the master stream.
// The sine is read at (accumulator + offset), the accumulator then advances by
// phase_increment, and the sine is scaled by a gain that ramps linearly to
// gain_target over ramp_length samples. The block takes one item per clock
// when no step division runs and the output is not stalled; items pass the
// registered stages index, four polynomial multiply stages, rounding, gain
// multiply, round and saturate, and stages with no item collapse so
// back-pressure only stalls as far as needed. A new gain_target with a non-zero
// ramp_length starts a bit-serial division for the per-sample step; s_tready
// stays low until the step is loaded. Other writes take effect at once. Writes
// are meant for when the stream is idle. Reset puts phase_increment at 42949673,
// gain_target at 0, ramp_length at 480, and clears phase, gain and ramp state.
module sine_oscillator_pm_gain_ramp #(
    parameter int TABLE_ADDRESS_BITS = sop_pkg::DEF_TABLE_ADDRESS_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave stream, tdata: phase_offset[31:0]
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [sop_pkg::PHASE_W-1:0]        i_s_tdata,
    // master stream, tdata: sample[15:0]
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [sop_pkg::SAMPLE_W-1:0]       o_m_tdata,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [sop_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sop_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int QB   = TABLE_ADDRESS_BITS - 2;
    localparam int NS   = sop_pkg::PIPE_STAGES;
    localparam int SS   = sop_pkg::SINE_STAGES;
    localparam int GW   = sop_pkg::GAIN_W;

    // ---- configuration and oscillator state ----
    logic [sop_pkg::INC_W-1:0]   r_phase_inc,   n_phase_inc;
    logic [sop_pkg::TGT_W-1:0]   r_gain_target, n_gain_target;
    logic [sop_pkg::LEN_W-1:0]   r_ramp_len,    n_ramp_len;
    logic [sop_pkg::PHASE_W-1:0] r_phase_acc,   n_phase_acc;
    logic [GW-1:0]               r_cur_gain,    n_cur_gain;
    logic [GW-1:0]               r_gain_step,   n_gain_step;
    logic [sop_pkg::LEN_W-1:0]   r_ramp_rem,    n_ramp_rem;
    logic                        r_step_neg,    n_step_neg;

    // ---- pipeline valid bits and per-stage advance ----
    logic [NS-1:0] r_vld, n_vld;
    logic [NS:0]   w_adv;
    logic          w_accept;

    // ---- step divider ----
    logic               w_div_start;
    logic [GW-1:0]      w_div_dividend;
    sop_pkg::t_div_stat w_div_stat;
    logic [GW-1:0]      w_div_quo;

    // ---- gain update for the current item ----
    logic [GW-1:0]        w_tgt31;
    logic signed [33:0]   w_gsum;
    logic signed [33:0]   w_tgt_s;
    logic [GW-1:0]        w_gain_step_val;
    logic [GW-1:0]        w_gain_now;
    logic                 w_ramp_on;
    logic [sop_pkg::LEN_W-1:0] w_rem_dec;

    // ---- target write ----
    logic [sop_pkg::TGT_W-1:0] w_tgt_sat;
    logic [32:0]               w_tdiff;

    // ---- phase indexing ----
    logic [sop_pkg::PHASE_W-1:0]    w_phase;
    logic [TABLE_ADDRESS_BITS-1:0]  w_tidx;
    logic [1:0]                     w_quad;
    logic [QB:0]                    w_pos;

    // ---- stage payloads ----
    logic [QB:0]   r_pos_0;
    logic          r_neg_0;
    logic [GW-1:0] r_gain [0:SS];     // gain travelling with its item
    logic [15:0]   w_mag;
    logic          w_sneg;
    logic [47:0]   r_prod_6;
    logic          r_neg_6;
    logic [47:0]   w_rnd;
    logic [16:0]   w_r;
    logic [sop_pkg::SAMPLE_W-1:0] r_out_7, n_out;

    // stage k moves when empty or when the stage after it moves
    always_comb begin
        w_adv[NS] = i_m_tready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    // the new step lands in the cycle the divider reports done, so items wait
    // through that cycle as well
    assign o_s_tready = w_adv[0] && !w_div_stat.busy && !w_div_stat.done;
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_vld = r_vld;
        if (w_adv[0]) begin
            n_vld[0] = w_accept;
        end
        for (int k = 1; k < NS; k++) begin
            if (w_adv[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    // table index: top bits of phase, mirrored in odd quadrants
    always_comb begin
        w_phase = r_phase_acc + i_s_tdata;
        w_tidx  = w_phase[sop_pkg::PHASE_W-1 -: TABLE_ADDRESS_BITS];
        w_quad  = w_tidx[TABLE_ADDRESS_BITS-1 -: 2];
        if (w_quad[0]) begin
            w_pos = ((QB+1)'(1) << QB) - {1'b0, w_tidx[QB-1:0]};
        end else begin
            w_pos = {1'b0, w_tidx[QB-1:0]};
        end
    end

    // gain ramp: one step per item, exact target on the last step, no overshoot
    always_comb begin
        w_tgt31   = {r_gain_target, 16'h0000};
        w_ramp_on = (r_ramp_rem != '0);
        w_rem_dec = r_ramp_rem - 1'b1;
        w_gsum    = $signed({2'b00, r_cur_gain})
                  + $signed({{2{r_gain_step[GW-1]}}, r_gain_step});
        w_tgt_s   = $signed({2'b00, w_tgt31});
        w_gain_step_val = w_gsum[GW-1:0];
        if (!r_gain_step[GW-1]) begin
            if (w_gsum > w_tgt_s) w_gain_step_val = w_tgt31;
        end else begin
            if (w_gsum < w_tgt_s) w_gain_step_val = w_tgt31;
        end
        if (!w_ramp_on) begin
            w_gain_now = r_cur_gain;
        end else if (w_rem_dec == '0) begin
            w_gain_now = w_tgt31;
        end else begin
            w_gain_now = w_gain_step_val;
        end
    end

    // target write: saturate to unity, signed distance to present gain
    always_comb begin
        w_tgt_sat = (i_cfg_data[sop_pkg::TGT_W-1:0] > sop_pkg::GAIN_UNITY)
                  ? sop_pkg::GAIN_UNITY : i_cfg_data[sop_pkg::TGT_W-1:0];
        w_tdiff   = {1'b0, w_tgt_sat, 16'h0000} - {1'b0, r_cur_gain};
        w_div_dividend = w_tdiff[32] ? GW'(-w_tdiff) : w_tdiff[GW-1:0];
    end

    always_comb begin
        n_phase_inc   = r_phase_inc;
        n_gain_target = r_gain_target;
        n_ramp_len    = r_ramp_len;
        n_phase_acc   = r_phase_acc;
        n_cur_gain    = r_cur_gain;
        n_gain_step   = r_gain_step;
        n_ramp_rem    = r_ramp_rem;
        n_step_neg    = r_step_neg;
        w_div_start   = 1'b0;

        if (w_accept) begin
            n_phase_acc = r_phase_acc + {1'b0, r_phase_inc};
            n_cur_gain  = w_gain_now;
            if (w_ramp_on) n_ramp_rem = w_rem_dec;
        end

        if (i_cfg_we) begin
            unique case (sop_pkg::t_cfg_idx'(i_cfg_idx))
                sop_pkg::CFG_PHASE_INC: begin
                    n_phase_inc = i_cfg_data[sop_pkg::INC_W-1:0];
                end
                sop_pkg::CFG_GAIN_TARGET: begin
                    // same target again leaves a running ramp alone
                    if (w_tgt_sat != r_gain_target) begin
                        n_gain_target = w_tgt_sat;
                        if (r_ramp_len == '0) begin
                            n_cur_gain  = {w_tgt_sat, 16'h0000};
                            n_gain_step = '0;
                            n_ramp_rem  = '0;
                        end else begin
                            n_ramp_rem  = r_ramp_len;
                            n_step_neg  = w_tdiff[32];
                            w_div_start = 1'b1;
                        end
                    end
                end
                sop_pkg::CFG_RAMP_LEN: begin
                    n_ramp_len = i_cfg_data[sop_pkg::LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end

        // quotient truncates toward zero, sign applied afterwards
        if (w_div_stat.done) begin
            n_gain_step = r_step_neg ? (~w_div_quo + 1'b1) : w_div_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc   <= sop_pkg::RST_PHASE_INC;
            r_gain_target <= sop_pkg::RST_GAIN_TARGET;
            r_ramp_len    <= sop_pkg::RST_RAMP_LEN;
            r_phase_acc   <= '0;
            r_cur_gain    <= '0;
            r_gain_step   <= '0;
            r_ramp_rem    <= '0;
            r_step_neg    <= 1'b0;
            r_vld         <= '0;
        end else begin
            r_phase_inc   <= n_phase_inc;
            r_gain_target <= n_gain_target;
            r_ramp_len    <= n_ramp_len;
            r_phase_acc   <= n_phase_acc;
            r_cur_gain    <= n_cur_gain;
            r_gain_step   <= n_gain_step;
            r_ramp_rem    <= n_ramp_rem;
            r_step_neg    <= n_step_neg;
            r_vld         <= n_vld;
        end
    end

    sop_div #(
        .DIVIDEND_W (GW),
        .DIVISOR_W  (sop_pkg::LEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (r_ramp_len),
        .o_stat     (w_div_stat),
        .o_quotient (w_div_quo)
    );

    // polynomial stages take the position held in the index stage
    sop_sine #(
        .TABLE_ADDRESS_BITS (TABLE_ADDRESS_BITS)
    ) u_sine (
        .i_clk (i_clk),
        .i_en  (w_adv[SS:1]),
        .i_pos (r_pos_0),
        .i_neg (r_neg_0),
        .o_mag (w_mag),
        .o_neg (w_sneg)
    );

    // round the scaled magnitude, restore sign, saturate
    always_comb begin
        w_rnd = r_prod_6 + 48'h0000_4000_0000;
        w_r   = w_rnd[47:31];
        if (r_neg_6) begin
            n_out = (w_r > 17'd32768) ? sop_pkg::SAMPLE_MIN
                                      : sop_pkg::SAMPLE_W'(~w_r + 1'b1);
        end else begin
            n_out = (w_r > 17'd32767) ? sop_pkg::SAMPLE_MAX : w_r[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_pos_0   <= w_pos;
            r_neg_0   <= w_quad[1];
            r_gain[0] <= w_gain_now;
        end
        for (int k = 1; k <= SS; k++) begin
            if (w_adv[k]) r_gain[k] <= r_gain[k-1];
        end
        if (w_adv[SS+1]) begin
            r_prod_6 <= w_mag * r_gain[SS];
            r_neg_6  <= w_sneg;
        end
        if (w_adv[SS+2]) begin
            r_out_7 <= n_out;
        end
    end

    assign o_m_tvalid = r_vld[NS-1];
    assign o_m_tdata  = r_out_7;

endmodule

// ===== rtl/core/sop_div.sv =====
// Bit-serial unsigned divider, one quotient bit per clock.
module sop_div #(
    parameter int DIVIDEND_W = sop_pkg::GAIN_W,
    parameter int DIVISOR_W  = sop_pkg::LEN_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output sop_pkg::t_div_stat    o_stat,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_divisor;

    logic [DIVISOR_W:0]    w_shift;
    logic                  w_ge;
    logic [DIVISOR_W-1:0]  n_rem;

    // remainder stays below divisor, so the difference fits DIVISOR_W bits
    always_comb begin
        w_shift = {r_rem, r_quo[DIVIDEND_W-1]};
        w_ge    = (w_shift >= {1'b0, r_divisor});
        n_rem   = w_ge ? DIVISOR_W'(w_shift - {1'b0, r_divisor})
                       : w_shift[DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quo     <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

// ===== rtl/core/sop_sine.sv =====
// Pipelined quarter-wave sine magnitude from a table position (polynomial form).
module sop_sine #(
    parameter int TABLE_ADDRESS_BITS = sop_pkg::DEF_TABLE_ADDRESS_BITS
) (
    input  logic                           i_clk,
    input  logic [sop_pkg::SINE_STAGES-1:0] i_en,
    input  logic [TABLE_ADDRESS_BITS-2:0]  i_pos,   // 0 .. 2^(bits-2)
    input  logic                           i_neg,
    output logic [15:0]                    o_mag,   // 0 .. 32768
    output logic                           o_neg
);

    localparam int QB       = TABLE_ADDRESS_BITS - 2;
    localparam int SQ_SHIFT = 30 - 2 * QB;

    // stage 1: x^2
    logic [30:0]   r_x2_1;
    logic [QB:0]   r_pos_1;
    logic          r_neg_1;
    // stage 2: u = B - C*x^2
    logic [29:0]   r_u_2;
    logic [30:0]   r_x2_2;
    logic [QB:0]   r_pos_2;
    logic          r_neg_2;
    // stage 3: w = A - u*x^2
    logic [30:0]   r_w_3;
    logic [QB:0]   r_pos_3;
    logic          r_neg_3;
    // stage 4: y = w*x
    logic [30:0]   r_y_4;
    logic          r_neg_4;
    // stage 5: rounded magnitude
    logic [15:0]   r_mag_5;
    logic          r_neg_5;

    logic [2*QB+1:0] w_sq;
    logic [57:0]     w_ct;
    logic [60:0]     w_uv;
    logic [QB+31:0]  w_wp;
    logic [30:0]     w_yc;
    logic [30:0]     w_rnd;

    always_comb begin
        w_sq  = i_pos * i_pos;
        w_ct  = r_x2_1 * sop_pkg::COEF_C;
        w_uv  = r_u_2 * r_x2_2;
        w_wp  = r_w_3 * r_pos_3;
        w_yc  = (r_y_4 > sop_pkg::ONE_Q30) ? sop_pkg::ONE_Q30 : r_y_4;
        w_rnd = w_yc + 31'h0000_4000;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x2_1  <= 31'(w_sq) << SQ_SHIFT;
            r_pos_1 <= i_pos;
            r_neg_1 <= i_neg;
        end
        if (i_en[1]) begin
            r_u_2   <= sop_pkg::COEF_B - {3'b000, w_ct[56:30]};
            r_x2_2  <= r_x2_1;
            r_pos_2 <= r_pos_1;
            r_neg_2 <= r_neg_1;
        end
        if (i_en[2]) begin
            r_w_3   <= sop_pkg::COEF_A - {1'b0, w_uv[59:30]};
            r_pos_3 <= r_pos_2;
            r_neg_3 <= r_neg_2;
        end
        if (i_en[3]) begin
            r_y_4   <= w_wp[QB+30:QB];
            r_neg_4 <= r_neg_3;
        end
        if (i_en[4]) begin
            r_mag_5 <= w_rnd[30:15];
            r_neg_5 <= r_neg_4;
        end
    end

    assign o_mag = r_mag_5;
    assign o_neg = r_neg_5;

endmodule
